>>> design/tcpo_pkg.sv
// Shared types, widths and constants of the two-color patch orientation core.
// Used by tcpo_accum, tcpo_engine and two_color_patch_orientation_core.
package tcpo_pkg;

  localparam int HUE_W        = 8;
  localparam int POS_W        = 8;
  localparam int COUNT_W      = 17;
  localparam int SUM_W        = 24;
  localparam int ANGLE_W      = 15;
  localparam int PROD_W       = SUM_W + COUNT_W;
  localparam int DIFF_W       = PROD_W + 2;
  localparam int VEC_W        = 46;
  localparam int ANG_W        = 28;
  localparam int CORDIC_STEPS = 24;
  localparam int ITER_W       = 5;
  localparam int NORM_BIT     = 40;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [HUE_W-1:0] HUE_LOW_RST  = 8'd10;
  localparam logic [HUE_W-1:0] HUE_HIGH_RST = 8'd20;

  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 1'd1;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI    = 28'sd26353589;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER_PI = 28'sd13176795;

  typedef struct packed {
    logic [COUNT_W-1:0] tc;
    logic [SUM_W-1:0]   tx;
    logic [SUM_W-1:0]   ty;
    logic [COUNT_W-1:0] rc;
    logic [SUM_W-1:0]   rx;
    logic [SUM_W-1:0]   ry;
  } acc_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input logic [ITER_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      5'd0:    r = 28'sd13176795;
      5'd1:    r = 28'sd7778716;
      5'd2:    r = 28'sd4110060;
      5'd3:    r = 28'sd2086331;
      5'd4:    r = 28'sd1047214;
      5'd5:    r = 28'sd524117;
      5'd6:    r = 28'sd262123;
      5'd7:    r = 28'sd131069;
      5'd8:    r = 28'sd65536;
      default: r = ANG_W'(1) << (5'd24 - i);
    endcase
    return r;
  endfunction

endpackage

>>> design/tcpo_accum.sv
// Per-class pixel count and coordinate sums with saturation.
// Depends on tcpo_pkg.
module tcpo_accum import tcpo_pkg::*; #(
  parameter int WINDOW_SIDE = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_en,
  input  logic             clear,
  input  logic [HUE_W-1:0] hue,
  input  logic             fg,
  input  logic [POS_W-1:0] pos_x,
  input  logic [POS_W-1:0] pos_y,
  input  logic [HUE_W-1:0] hue_low,
  input  logic [HUE_W-1:0] hue_high,
  output acc_t             acc_nxt
);

  acc_t acc_r;
  logic in_win, team, hit;

  function automatic logic [COUNT_W-1:0] sat_cnt(input logic [COUNT_W-1:0] a);
    return (&a) ? a : a + COUNT_W'(1);
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  assign in_win = (int'(pos_x) < WINDOW_SIDE) && (int'(pos_y) < WINDOW_SIDE);
  assign team   = (hue >= hue_low) && (hue <= hue_high);
  assign hit    = acc_en && fg && in_win;

  always_comb begin
    acc_nxt = acc_r;
    if (hit && team) begin
      acc_nxt.tc = sat_cnt(acc_r.tc);
      acc_nxt.tx = sat_sum(acc_r.tx, pos_x);
      acc_nxt.ty = sat_sum(acc_r.ty, pos_y);
    end else if (hit) begin
      acc_nxt.rc = sat_cnt(acc_r.rc);
      acc_nxt.rx = sat_sum(acc_r.rx, pos_x);
      acc_nxt.ry = sat_sum(acc_r.ry, pos_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

>>> design/tcpo_engine.sv
// Sequenced centroid difference, normalization and CORDIC angle unit.
// One shared multiplier then one shared shift/add datapath. Depends on tcpo_pkg.
module tcpo_engine import tcpo_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  acc_t               acc,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ANGLE_W-1:0] out_angle,
  output logic               out_empty_class
);

  localparam int RND_SH = 24 - ANGLE_FRAC_BITS;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_PREP, S_NORM, S_ROT, S_ROUND, S_DONE} state_t;

  state_t                   state_r;
  acc_t                     acc_r;
  logic [2:0]               cnt_r;
  logic [ITER_W-1:0]        iter_r;
  logic [PROD_W-1:0]        prod_r, a_r, prod;
  logic [SUM_W-1:0]         mul_a;
  logic [COUNT_W-1:0]       mul_b;
  logic signed [DIFF_W-1:0] dx_r, dy_raw;
  logic signed [VEC_W-1:0]  x_r, y_r, xs, ys, vmax;
  logic signed [ANG_W-1:0]  z_r, v, vr;
  logic [ANGLE_W-1:0]       res_angle_r;
  logic                     res_empty_r;
  logic                     out_valid_r;
  logic [ANGLE_W-1:0]       out_angle_r;
  logic                     out_empty_r;

  always_comb begin
    case (cnt_r)
      3'd0:    begin mul_a = acc_r.rx; mul_b = acc_r.tc; end
      3'd1:    begin mul_a = acc_r.tx; mul_b = acc_r.rc; end
      3'd2:    begin mul_a = acc_r.ry; mul_b = acc_r.tc; end
      default: begin mul_a = acc_r.ty; mul_b = acc_r.rc; end
    endcase
  end

  assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign dy_raw = $signed({2'b00, a_r}) - $signed({2'b00, prod_r});
  assign xs     = x_r >>> iter_r;
  assign ys     = y_r >>> iter_r;
  assign vmax   = (x_r > y_r) ? x_r : y_r;
  assign v      = z_r - ANG_QUARTER_PI;
  assign vr     = (v + (ANG_W'(1) << (RND_SH - 1))) >>> RND_SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            acc_r <= acc;
            cnt_r <= '0;
            if (acc.tc == '0 || acc.rc == '0) begin
              res_angle_r <= '0;
              res_empty_r <= 1'b1;
              state_r     <= S_DONE;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r <= prod;
          cnt_r  <= cnt_r + 3'd1;
          if (cnt_r == 3'd1 || cnt_r == 3'd3) begin
            a_r <= prod_r;
          end
          if (cnt_r == 3'd2) begin
            dx_r <= dy_raw;
          end
          if (cnt_r == 3'd4) begin
            y_r     <= VEC_W'(dy_raw < 0 ? -dy_raw : dy_raw);
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          iter_r <= '0;
          if (dx_r == '0 && y_r == '0) begin
            z_r     <= '0;
            state_r <= S_ROUND;
          end else if (dx_r < 0) begin
            x_r     <= y_r;
            y_r     <= -VEC_W'(dx_r);
            z_r     <= ANG_HALF_PI;
            state_r <= S_NORM;
          end else begin
            x_r     <= VEC_W'(dx_r);
            z_r     <= '0;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (vmax < (VEC_W'(1) <<< NORM_BIT)) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          if (y_r >= 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_step(iter_r);
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_step(iter_r);
          end
          iter_r <= iter_r + ITER_W'(1);
          if (iter_r == ITER_W'(CORDIC_STEPS - 1)) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          res_angle_r <= vr[ANGLE_W-1:0];
          res_empty_r <= 1'b0;
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_angle_r <= res_angle_r;
            out_empty_r <= res_empty_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_angle       = out_angle_r;
  assign out_empty_class = out_empty_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE) else $error("start while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy) else $error("start not taken");
  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROT |-> iter_r < ITER_W'(CORDIC_STEPS)) else $error("iteration overrun");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_angle_r == '0) else $error("empty result not zero");

endmodule

>>> design/two_color_patch_orientation_core.sv
// Top level of the two-color patch orientation core.
// Instantiates tcpo_accum and tcpo_engine; depends on tcpo_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel per transfer: hue,
//   foreground bit, column, row and a last-pixel mark. Pixels are taken one
//   per clock while the angle unit is idle.
//   A transfer with in_last_pixel set closes the window: in_stall rises and
//   the angle unit runs. An empty class goes straight to the load step;
//   otherwise it runs the multiply steps on the shared multiplier, setup,
//   normalization (one bit of left shift per cycle), 24 CORDIC iterations
//   on the shared shift/add datapath, rounding and load (no normalization
//   or CORDIC if the centroids coincide). The result is valid right after.
//   Output channel (out_valid / out_stall) carries one result per window:
//   out_angle (signed, ANGLE_FRAC_BITS fraction bits) and out_empty_class.
//   The result register holds while out_stall is high; the unit keeps its
//   finished result and stays busy until the register frees.
//   Configuration writes (cfg_we, cfg_index, cfg_data) set the team hue
//   bounds; write them only while no window is in flight. Reset clears the
//   accumulators, drops out_valid and restores hue bounds 10 and 20.
module two_color_patch_orientation_core import tcpo_pkg::*; #(
  parameter int WINDOW_SIDE     = 256,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [HUE_W-1:0]      in_hue,
  input  logic                  in_in_mask,
  input  logic [POS_W-1:0]      in_pos_x,
  input  logic [POS_W-1:0]      in_pos_y,
  input  logic                  in_last_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [ANGLE_W-1:0] out_angle,
  output logic                  out_empty_class,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [HUE_W-1:0]   hue_low_r, hue_high_r;
  logic               busy, take, start;
  logic [ANGLE_W-1:0] angle;
  acc_t               acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= HUE_LOW_RST;
      hue_high_r <= HUE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUE_LOW:  hue_low_r  <= cfg_data[HUE_W-1:0];
        REG_HUE_HIGH: hue_high_r <= cfg_data[HUE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = busy;
  assign take     = in_valid && !busy;
  assign start    = take && in_last_pixel;

  tcpo_accum #(.WINDOW_SIDE(WINDOW_SIDE)) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_en   (take),
    .clear    (start),
    .hue      (in_hue),
    .fg       (in_in_mask),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .hue_low  (hue_low_r),
    .hue_high (hue_high_r),
    .acc_nxt  (acc_nxt)
  );

  tcpo_engine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .acc             (acc_nxt),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_angle       (angle),
    .out_empty_class (out_empty_class)
  );

  assign out_angle = $signed(angle);

endmodule
